FILE: rtl/vas_pkg.sv
// shared widths, command and register codes, and the voice table entry type
// used by the voice allocator top level and its port checker; no dependencies
`default_nettype none

package vas_pkg;

  localparam int unsigned NUM_VOICES_DEF = 16;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned KEY_W     = 7;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned VEL_W     = 7;
  localparam int unsigned PAN_W     = 7;
  localparam int unsigned VOICE_W   = 4;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_NOTE_ON    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHOKE      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KILL_ALL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VOICE_DONE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LOADED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_ITSELF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_ENV_ON    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ON       = 3'd3;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CHAN_W-1:0]  chan;
    logic [STAMP_W-1:0] stamp;
  } voice_entry_t;

endpackage

`default_nettype wire

FILE: rtl/vas_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module vas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/voice_allocator_with_stealing_unit.sv
// polyphonic voice allocator with oldest-voice stealing
// depends on vas_pkg and vas_ram
//
// usage:
//   input channel (in_valid_i / in_stall_o) takes one event item: note on,
//   note off, choke, kill all or voice finished. output channel
//   (out_valid_o / out_stall_i) returns exactly one result item per event.
//   the config write channel (cfg_valid_i / cfg_ready_o) is always ready and
//   should only be written while no event is in flight.
// sequence: note on scans every voice entry, then writes the chosen entry
//   and finishes; with cut_itself set it skips the scan. note off and choke
//   scan and then finish; kill all, voice finished, note on without a sample
//   and unknown commands go straight to the final state. the scan reads one
//   voice entry per cycle from the voice table ram through one shared stamp
//   comparator. in_stall_o is high from accept until the result moves into
//   the output register, so the next item can be taken in the following cycle.
// reset: all voices idle, stamp counter zero, sample_loaded 0, cut_itself 0,
//   amp_env_on 1, loop_on 0; no clearing pass is needed.
// a stalled result holds in the output register; the next event is taken
//   meanwhile, and its result waits in the final state until the slot frees.
`default_nettype none

module voice_allocator_with_stealing_unit #(
  parameter int unsigned NUM_VOICES = vas_pkg::NUM_VOICES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vas_pkg::CMD_W-1:0]      cmd_i,
  input  logic [vas_pkg::KEY_W-1:0]      note_key_i,
  input  logic [vas_pkg::CHAN_W-1:0]     note_channel_i,
  input  logic                           any_channel_i,
  input  logic [vas_pkg::VEL_W-1:0]      note_velocity_i,
  input  logic signed [vas_pkg::PAN_W-1:0] note_pan_i,
  input  logic [vas_pkg::VOICE_W-1:0]    done_voice_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           started_o,
  output logic [vas_pkg::VOICE_W-1:0]    start_voice_o,
  output logic [vas_pkg::KEY_W-1:0]      start_key_o,
  output logic [vas_pkg::CHAN_W-1:0]     start_channel_o,
  output logic [vas_pkg::VEL_W-1:0]      start_velocity_o,
  output logic signed [vas_pkg::PAN_W-1:0] start_pan_o,
  output logic [vas_pkg::MASK_W-1:0]     release_mask_o,
  output logic                           release_fast_o,
  output logic [vas_pkg::MASK_W-1:0]     kill_mask_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vas_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic                           cfg_data_i
);

  import vas_pkg::*;

  localparam int unsigned VW = $clog2(NUM_VOICES);
  localparam int unsigned CW = $clog2(NUM_VOICES + 1);
  localparam logic [VW-1:0] LAST_IDX = VW'(NUM_VOICES - 1);
  localparam logic [CW-1:0] SCAN_END = CW'(NUM_VOICES);
  localparam int unsigned EW = $bits(voice_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_e;

  // voices below sixteen own a bit in the masks
  function automatic logic [MASK_W-1:0] low_mask(input logic [NUM_VOICES-1:0] v);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < NUM_VOICES) begin
        m[b] = v[b];
      end
    end
    return m;
  endfunction

  function automatic logic [MASK_W-1:0] bit_of(input logic [VW-1:0] idx);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < NUM_VOICES) begin
        m[b] = (idx == VW'(b));
      end
    end
    return m;
  endfunction

  state_e state_q, state_d;

  logic sample_loaded_q, sample_loaded_d;
  logic cut_itself_q, cut_itself_d;
  logic amp_env_on_q, amp_env_on_d;
  logic loop_on_q, loop_on_d;

  logic [NUM_VOICES-1:0] active_q, active_d;
  logic [NUM_VOICES-1:0] rel_q, rel_d;
  logic [STAMP_W-1:0]    stamp_cnt_q, stamp_cnt_d;

  logic [CW-1:0] scan_cnt_q, scan_cnt_d;
  logic          chk_valid_q, chk_valid_d;
  logic [VW-1:0] chk_idx_q, chk_idx_d;

  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic [KEY_W-1:0]         key_q, key_d;
  logic [CHAN_W-1:0]        chan_q, chan_d;
  logic                     any_q, any_d;
  logic [VEL_W-1:0]         vel_q, vel_d;
  logic signed [PAN_W-1:0]  pan_q, pan_d;

  logic               idle_found_q, idle_found_d;
  logic [VW-1:0]      idle_idx_q, idle_idx_d;
  logic               have_best_q, have_best_d;
  logic               best_pri_q, best_pri_d;
  logic [STAMP_W-1:0] best_stamp_q, best_stamp_d;
  logic [VW-1:0]      best_idx_q, best_idx_d;
  logic [MASK_W-1:0]  rel_mask_q, rel_mask_d;
  logic [MASK_W-1:0]  kill_mask_q, kill_mask_d;
  logic               started_q, started_d;
  logic [VW-1:0]      pick_q, pick_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_started_q, out_started_d;
  logic [VOICE_W-1:0]      out_voice_q, out_voice_d;
  logic [KEY_W-1:0]        out_key_q, out_key_d;
  logic [CHAN_W-1:0]       out_chan_q, out_chan_d;
  logic [VEL_W-1:0]        out_vel_q, out_vel_d;
  logic signed [PAN_W-1:0] out_pan_q, out_pan_d;
  logic [MASK_W-1:0]       out_rel_q, out_rel_d;
  logic                    out_fast_q, out_fast_d;
  logic [MASK_W-1:0]       out_kill_q, out_kill_d;

  logic          ram_we;
  logic [VW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [VW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  voice_entry_t       rd_entry;
  voice_entry_t       wr_entry;
  logic               cur_active;
  logic               cur_rel;
  logic               key_hit;
  logic               chan_hit;
  logic [STAMP_W:0]   cand;
  logic [STAMP_W:0]   best;
  logic [VW-1:0]      pick_sel;
  logic [STAMP_W-1:0] stamp_inc;
  logic [VW-1:0]      done_idx;
  logic               done_ok;

  vas_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_VOICES)
  ) u_voice_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry   = voice_entry_t'(ram_rdata);
  assign cur_active = active_q[chk_idx_q];
  assign cur_rel    = rel_q[chk_idx_q];
  assign key_hit    = (rd_entry.key == key_q);
  assign chan_hit   = any_q || (rd_entry.chan == chan_q);
  // releasing voices rank ahead of held ones, then the smaller stamp
  assign cand       = {~cur_rel, rd_entry.stamp};
  assign best       = {best_pri_q, best_stamp_q};
  assign pick_sel   = idle_found_q ? idle_idx_q : best_idx_q;
  assign stamp_inc  = STAMP_W'(stamp_cnt_q + 1'b1);
  assign done_idx   = VW'(done_voice_i);
  assign done_ok    = (32'(done_voice_i) < 32'(NUM_VOICES));

  assign wr_entry.key   = key_q;
  assign wr_entry.chan  = chan_q;
  assign wr_entry.stamp = stamp_inc;

  assign ram_we    = (state_q == ST_WRITE);
  assign ram_waddr = pick_sel;
  assign ram_wdata = wr_entry;
  assign ram_re    = (state_q == ST_SCAN) && (scan_cnt_q != SCAN_END);
  assign ram_raddr = scan_cnt_q[VW-1:0];

  always_comb begin
    state_d         = state_q;
    sample_loaded_d = sample_loaded_q;
    cut_itself_d    = cut_itself_q;
    amp_env_on_d    = amp_env_on_q;
    loop_on_d       = loop_on_q;
    active_d        = active_q;
    rel_d           = rel_q;
    stamp_cnt_d     = stamp_cnt_q;
    scan_cnt_d      = scan_cnt_q;
    chk_valid_d     = chk_valid_q;
    chk_idx_d       = chk_idx_q;
    cmd_d           = cmd_q;
    key_d           = key_q;
    chan_d          = chan_q;
    any_d           = any_q;
    vel_d           = vel_q;
    pan_d           = pan_q;
    idle_found_d    = idle_found_q;
    idle_idx_d      = idle_idx_q;
    have_best_d     = have_best_q;
    best_pri_d      = best_pri_q;
    best_stamp_d    = best_stamp_q;
    best_idx_d      = best_idx_q;
    rel_mask_d      = rel_mask_q;
    kill_mask_d     = kill_mask_q;
    started_d       = started_q;
    pick_d          = pick_q;
    out_valid_d     = out_valid_q;
    out_started_d   = out_started_q;
    out_voice_d     = out_voice_q;
    out_key_d       = out_key_q;
    out_chan_d      = out_chan_q;
    out_vel_d       = out_vel_q;
    out_pan_d       = out_pan_q;
    out_rel_d       = out_rel_q;
    out_fast_d      = out_fast_q;
    out_kill_d      = out_kill_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_LOADED: sample_loaded_d = cfg_data_i;
        CFG_CUT_ITSELF:    cut_itself_d    = cfg_data_i;
        CFG_AMP_ENV_ON:    amp_env_on_d    = cfg_data_i;
        CFG_LOOP_ON:       loop_on_d       = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_i;
          key_d        = note_key_i;
          chan_d       = note_channel_i;
          any_d        = any_channel_i;
          vel_d        = note_velocity_i;
          pan_d        = note_pan_i;
          idle_found_d = 1'b0;
          idle_idx_d   = '0;
          have_best_d  = 1'b0;
          rel_mask_d   = '0;
          kill_mask_d  = '0;
          started_d    = 1'b0;
          pick_d       = '0;
          scan_cnt_d   = '0;
          chk_valid_d  = 1'b0;
          state_d      = ST_FINISH;
          unique case (cmd_i)
            CMD_NOTE_ON: begin
              if (sample_loaded_q) begin
                if (cut_itself_q) begin
                  // everything dies, so voice 0 is the first idle one
                  kill_mask_d  = low_mask(active_q);
                  active_d     = '0;
                  rel_d        = '0;
                  idle_found_d = 1'b1;
                  state_d      = ST_WRITE;
                end else begin
                  state_d = ST_SCAN;
                end
              end
            end
            CMD_NOTE_OFF, CMD_CHOKE: begin
              state_d = ST_SCAN;
            end
            CMD_KILL_ALL: begin
              kill_mask_d = low_mask(active_q);
              active_d    = '0;
              rel_d       = '0;
            end
            CMD_VOICE_DONE: begin
              if (done_ok) begin
                if (active_q[done_idx]) begin
                  kill_mask_d = bit_of(done_idx);
                end
                active_d[done_idx] = 1'b0;
                rel_d[done_idx]    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // ram read issued here, entry checked in the next cycle
        if (scan_cnt_q != SCAN_END) begin
          scan_cnt_d  = CW'(scan_cnt_q + 1'b1);
          chk_valid_d = 1'b1;
          chk_idx_d   = scan_cnt_q[VW-1:0];
        end else begin
          chk_valid_d = 1'b0;
        end

        if (chk_valid_q) begin
          case (cmd_q)
            CMD_NOTE_ON: begin
              if (!cur_active) begin
                if (!idle_found_q) begin
                  idle_found_d = 1'b1;
                  idle_idx_d   = chk_idx_q;
                end
              end else if (!have_best_q || (cand < best)) begin
                have_best_d  = 1'b1;
                best_pri_d   = cand[STAMP_W];
                best_stamp_d = cand[STAMP_W-1:0];
                best_idx_d   = chk_idx_q;
              end
            end
            CMD_NOTE_OFF: begin
              if (cur_active && !cur_rel && key_hit && chan_hit) begin
                rel_d[chk_idx_q] = 1'b1;
                rel_mask_d       = rel_mask_q | bit_of(chk_idx_q);
              end
            end
            CMD_CHOKE: begin
              if (cur_active && key_hit) begin
                active_d[chk_idx_q] = 1'b0;
                rel_d[chk_idx_q]    = 1'b0;
                kill_mask_d         = kill_mask_q | bit_of(chk_idx_q);
              end
            end
            default: ;
          endcase

          if (chk_idx_q == LAST_IDX) begin
            state_d = (cmd_q == CMD_NOTE_ON) ? ST_WRITE : ST_FINISH;
          end
        end
      end

      ST_WRITE: begin
        active_d[pick_sel] = 1'b1;
        rel_d[pick_sel]    = 1'b0;
        stamp_cnt_d        = stamp_inc;
        started_d          = 1'b1;
        pick_d             = pick_sel;
        state_d            = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_started_d = started_q;
          out_voice_d   = started_q ? VOICE_W'(pick_q) : '0;
          out_key_d     = started_q ? key_q : '0;
          out_chan_d    = started_q ? chan_q : '0;
          out_vel_d     = started_q ? vel_q : '0;
          out_pan_d     = started_q ? pan_q : '0;
          out_rel_d     = rel_mask_q;
          out_fast_d    = (cmd_q == CMD_NOTE_OFF) && !amp_env_on_q && loop_on_q;
          out_kill_d    = kill_mask_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      sample_loaded_q <= 1'b0;
      cut_itself_q    <= 1'b0;
      amp_env_on_q    <= 1'b1;
      loop_on_q       <= 1'b0;
      active_q        <= '0;
      rel_q           <= '0;
      stamp_cnt_q     <= '0;
      scan_cnt_q      <= '0;
      chk_valid_q     <= 1'b0;
      chk_idx_q       <= '0;
      cmd_q           <= '0;
      key_q           <= '0;
      chan_q          <= '0;
      any_q           <= 1'b0;
      vel_q           <= '0;
      pan_q           <= '0;
      idle_found_q    <= 1'b0;
      idle_idx_q      <= '0;
      have_best_q     <= 1'b0;
      best_pri_q      <= 1'b0;
      best_stamp_q    <= '0;
      best_idx_q      <= '0;
      rel_mask_q      <= '0;
      kill_mask_q     <= '0;
      started_q       <= 1'b0;
      pick_q          <= '0;
      out_valid_q     <= 1'b0;
      out_started_q   <= 1'b0;
      out_voice_q     <= '0;
      out_key_q       <= '0;
      out_chan_q      <= '0;
      out_vel_q       <= '0;
      out_pan_q       <= '0;
      out_rel_q       <= '0;
      out_fast_q      <= 1'b0;
      out_kill_q      <= '0;
    end else begin
      state_q         <= state_d;
      sample_loaded_q <= sample_loaded_d;
      cut_itself_q    <= cut_itself_d;
      amp_env_on_q    <= amp_env_on_d;
      loop_on_q       <= loop_on_d;
      active_q        <= active_d;
      rel_q           <= rel_d;
      stamp_cnt_q     <= stamp_cnt_d;
      scan_cnt_q      <= scan_cnt_d;
      chk_valid_q     <= chk_valid_d;
      chk_idx_q       <= chk_idx_d;
      cmd_q           <= cmd_d;
      key_q           <= key_d;
      chan_q          <= chan_d;
      any_q           <= any_d;
      vel_q           <= vel_d;
      pan_q           <= pan_d;
      idle_found_q    <= idle_found_d;
      idle_idx_q      <= idle_idx_d;
      have_best_q     <= have_best_d;
      best_pri_q      <= best_pri_d;
      best_stamp_q    <= best_stamp_d;
      best_idx_q      <= best_idx_d;
      rel_mask_q      <= rel_mask_d;
      kill_mask_q     <= kill_mask_d;
      started_q       <= started_d;
      pick_q          <= pick_d;
      out_valid_q     <= out_valid_d;
      out_started_q   <= out_started_d;
      out_voice_q     <= out_voice_d;
      out_key_q       <= out_key_d;
      out_chan_q      <= out_chan_d;
      out_vel_q       <= out_vel_d;
      out_pan_q       <= out_pan_d;
      out_rel_q       <= out_rel_d;
      out_fast_q      <= out_fast_d;
      out_kill_q      <= out_kill_d;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign started_o        = out_started_q;
  assign start_voice_o    = out_voice_q;
  assign start_key_o      = out_key_q;
  assign start_channel_o  = out_chan_q;
  assign start_velocity_o = out_vel_q;
  assign start_pan_o      = out_pan_q;
  assign release_mask_o   = out_rel_q;
  assign release_fast_o   = out_fast_q;
  assign kill_mask_o      = out_kill_q;

endmodule

`default_nettype wire

FILE: rtl/vas_checker.sv
// port-level assertions for the voice allocator, bound to its top level
// depends on vas_pkg and voice_allocator_with_stealing_unit
`default_nettype none

module vas_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic                           started_o,
  input wire logic [vas_pkg::VOICE_W-1:0]    start_voice_o,
  input wire logic [vas_pkg::KEY_W-1:0]      start_key_o,
  input wire logic [vas_pkg::CHAN_W-1:0]     start_channel_o,
  input wire logic [vas_pkg::VEL_W-1:0]      start_velocity_o,
  input wire logic [vas_pkg::PAN_W-1:0]      start_pan_o,
  input wire logic [vas_pkg::MASK_W-1:0]     release_mask_o,
  input wire logic                           release_fast_o,
  input wire logic [vas_pkg::MASK_W-1:0]     kill_mask_o
);

  // an accepted item closes the input side in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(kill_mask_o) && $stable(release_mask_o)
       && $stable(started_o) && $stable(start_voice_o)))
    else $error("stalled result changed");

  // start fields are zero when no voice was started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !started_o) |->
      (start_voice_o == '0 && start_key_o == '0 && start_channel_o == '0
       && start_velocity_o == '0 && start_pan_o == '0))
    else $error("start fields set without a start");

  // a note on never releases and a release never comes with a kill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((!started_o || (release_mask_o == '0 && !release_fast_o))
       && (release_mask_o == '0 || kill_mask_o == '0)))
    else $error("release mixed with start or kill");

  // the release fast flag only comes with a result that started no voice and killed none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && release_fast_o) |-> (!started_o && kill_mask_o == '0))
    else $error("fast release flag on a non note-off result");

endmodule

bind voice_allocator_with_stealing_unit vas_checker u_vas_checker (.*);

`default_nettype wire
